// ===== hw/rtl/gln_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gln_pkg
// Shared types, constants and saturating helpers of the Gauss-Legendre node
// generator.
// ----------------------------------------------------------------------------
package gln_pkg;

    localparam int FRAC_BITS_DEF        = 44;
    localparam int MAX_ORDER_DEF        = 64;
    localparam int MAX_NEWTON_STEPS_DEF = 16;
    localparam int COS_TERMS            = 12;

    localparam logic [63:0]        PI_Q62  = 64'hC90F_DAA2_2168_C234;
    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        REG_RULE_ORDER     = 1'b0,
        REG_CONVERGE_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic {
        AU_MUL = 1'b0,
        AU_DIV = 1'b1
    } t_au_op;

    // request to the shared arithmetic unit
    typedef struct packed {
        logic               start;
        t_au_op             op;
        logic               frac;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_au_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } t_au_rsp;

    function automatic logic [63:0] mag64(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'(SAT_MAX)) begin
            return SAT_MAX;
        end
        if (s < -65'(SAT_MAX)) begin
            return -SAT_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
        return (a == {1'b1, 63'b0}) ? SAT_MAX : -a;
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        return sat_add(a, sat_neg(b));
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gln_arith.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gln_arith
// Shared saturating multiply (64x16 per cycle, four passes) and restoring
// divide (one quotient bit per cycle) on signed 64-bit fixed-point values.
// ----------------------------------------------------------------------------
module gln_arith #(
    parameter int FRAC_BITS = gln_pkg::FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire gln_pkg::t_au_req i_req,
    output gln_pkg::t_au_rsp      o_rsp
);

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIN  = 4'b1000
    } t_ustate;

    t_ustate r_ust;
    logic [7:0]         r_cnt;
    logic [63:0]        r_mx;
    logic [63:0]        r_my;
    logic [127:0]       r_acc;
    logic [127:0]       r_num;
    logic [63:0]        r_rem;
    logic [127:0]       r_q;
    logic               r_neg;
    logic               r_frac;
    logic               r_is_div;
    logic               r_a_zero;
    logic               r_a_neg;
    logic               r_d_zero;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [5:0]         w_sh;
    logic [15:0]        w_slice;
    logic [79:0]        w_prod;
    logic [127:0]       w_pp;
    logic [64:0]        w_rem2;
    logic               w_ge;
    logic [64:0]        w_sub;
    logic [127:0]       w_full;
    logic               w_ovf;
    logic signed [63:0] w_res;

    always_comb begin
        w_sh    = {r_cnt[1:0], 4'b0000};
        w_slice = r_my[w_sh +: 16];
        w_prod  = r_mx * w_slice;
        w_pp    = {48'b0, w_prod} << w_sh;

        w_rem2  = {r_rem, r_num[127]};
        w_ge    = (w_rem2 >= {1'b0, r_my});
        w_sub   = w_rem2 - {1'b0, r_my};

        if (r_is_div) begin
            w_full = r_q;
        end else if (r_frac) begin
            w_full = r_acc >> FRAC_BITS;
        end else begin
            w_full = r_acc;
        end
        w_ovf = |w_full[127:63];

        if (r_is_div && r_d_zero) begin
            // divide by zero: zero for a zero dividend, else full scale
            if (r_a_zero) begin
                w_res = '0;
            end else begin
                w_res = r_a_neg ? -gln_pkg::SAT_MAX : gln_pkg::SAT_MAX;
            end
        end else if (w_ovf) begin
            w_res = r_neg ? -gln_pkg::SAT_MAX : gln_pkg::SAT_MAX;
        end else begin
            w_res = r_neg ? -$signed(w_full[63:0]) : $signed(w_full[63:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ust  <= U_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_ust)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_mx     <= gln_pkg::mag64(i_req.a);
                        r_my     <= gln_pkg::mag64(i_req.b);
                        r_neg    <= i_req.a[63] ^ i_req.b[63];
                        r_frac   <= i_req.frac;
                        r_is_div <= (i_req.op == gln_pkg::AU_DIV);
                        r_a_zero <= (i_req.a == '0);
                        r_a_neg  <= i_req.a[63];
                        r_d_zero <= (i_req.b == '0);
                        r_acc    <= '0;
                        r_rem    <= '0;
                        r_q      <= '0;
                        if (i_req.frac) begin
                            r_num <= {64'b0, gln_pkg::mag64(i_req.a)} << FRAC_BITS;
                        end else begin
                            r_num <= {gln_pkg::mag64(i_req.a), 64'b0};
                        end
                        if (i_req.op == gln_pkg::AU_MUL) begin
                            r_cnt <= 8'd0;
                            r_ust <= U_MUL;
                        end else begin
                            r_cnt <= i_req.frac ? 8'd127 : 8'd63;
                            r_ust <= U_DIV;
                        end
                    end
                end
                U_MUL: begin
                    r_acc <= r_acc + w_pp;
                    r_cnt <= r_cnt + 8'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_ust <= U_FIN;
                    end
                end
                U_DIV: begin
                    r_num <= {r_num[126:0], 1'b0};
                    r_rem <= w_ge ? w_sub[63:0] : w_rem2[63:0];
                    r_q   <= {r_q[126:0], w_ge};
                    if (r_cnt == 8'd0) begin
                        r_ust <= U_FIN;
                    end else begin
                        r_cnt <= r_cnt - 8'd1;
                    end
                end
                U_FIN: begin
                    r_res  <= w_res;
                    r_done <= 1'b1;
                    r_ust  <= U_IDLE;
                end
                default: begin
                    r_ust <= U_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule
`default_nettype wire

// ===== hw/rtl/gauss_legendre_node_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gauss_legendre_node_generator
// Computes one node and weight of the k-point Gauss-Legendre rule per index.
// ----------------------------------------------------------------------------
// Usage: write rule_order (index 0) and converge_limit (index 1) through the
// cfg port while idle. Present node_index with i_in_valid; the transaction is
// taken when o_in_stall is low. The block then seeds the root with a cosine
// series and refines it by Newton steps, all on one shared multiply/divide
// unit under a sequencer, and finishes with the weight.
// Out-of-range items skip the computation and finish with range status.
// One item is in work at a time; o_in_stall is high until its result moves
// to the output register, so a new item may start while the previous result
// is still held. The result holds while i_out_stall is high; a finished
// item waits in the sequencer until the output register frees up.
// Reset: rule_order returns to 1, converge_limit to 4, both channels empty.
// ----------------------------------------------------------------------------
module gauss_legendre_node_generator #(
    parameter int MAX_ORDER        = gln_pkg::MAX_ORDER_DEF,
    parameter int MAX_NEWTON_STEPS = gln_pkg::MAX_NEWTON_STEPS_DEF,
    parameter int FRAC_BITS        = gln_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [5:0]         i_node_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [47:0]      o_node_coord,
    output logic [46:0]             o_node_weight,
    output logic [1:0]              o_status
);

    localparam int STEP_W = $clog2(MAX_NEWTON_STEPS + 1);
    localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] PI_FX = 64'(gln_pkg::PI_Q62 >> (62 - FRAC_BITS));
    localparam logic signed [63:0] C_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] C_MIN = -64'sh0000_8000_0000_0000;

    typedef enum logic [18:0] {
        S_IDLE     = 19'(1 << 0),
        S_SEED_DIV = 19'(1 << 1),
        S_SEED_MUL = 19'(1 << 2),
        S_COS_T2   = 19'(1 << 3),
        S_COS_MUL  = 19'(1 << 4),
        S_COS_DIV  = 19'(1 << 5),
        S_REC_M1   = 19'(1 << 6),
        S_REC_M2   = 19'(1 << 7),
        S_REC_M3   = 19'(1 << 8),
        S_REC_DIV  = 19'(1 << 9),
        S_NT_D     = 19'(1 << 10),
        S_NT_ZZ    = 19'(1 << 11),
        S_NT_NUM   = 19'(1 << 12),
        S_NT_DEN   = 19'(1 << 13),
        S_NT_DZ    = 19'(1 << 14),
        S_W_ZZ     = 19'(1 << 15),
        S_W_DIV1   = 19'(1 << 16),
        S_W_DIV2   = 19'(1 << 17),
        S_DONE     = 19'(1 << 18)
    } t_state;

    t_state r_state;
    logic               r_wait;
    logic [6:0]         r_rule_order;
    logic [15:0]        r_converge_limit;
    logic               r_lower;
    logic [6:0]         r_i;
    logic [6:0]         r_j;
    logic [3:0]         r_cn;
    logic [9:0]         r_cdiv;
    logic [STEP_W-1:0]  r_steps;
    logic signed [63:0] r_ta;
    logic signed [63:0] r_tb;
    logic signed [63:0] r_t2;
    logic signed [63:0] r_term;
    logic signed [63:0] r_sum;
    logic signed [63:0] r_z;
    logic signed [63:0] r_z1;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;
    logic signed [63:0] r_p3;
    logic signed [63:0] r_d;
    logic signed [63:0] r_den;
    logic signed [47:0] r_fc;
    logic [46:0]        r_fw;
    gln_pkg::t_status   r_fs;
    logic               r_out_valid;
    logic signed [47:0] r_coord;
    logic [46:0]        r_weight;
    gln_pkg::t_status   r_status;

    gln_pkg::t_au_req   w_req;
    gln_pkg::t_au_rsp   w_rsp;
    logic               w_in_acc;
    logic               w_out_load;
    logic signed [63:0] w_res;
    logic signed [63:0] w_cos_sum;
    logic signed [63:0] w_omz;
    logic signed [63:0] w_cv;
    logic [STEP_W-1:0]  w_steps_nx;
    logic               w_lower;
    logic [6:0]         w_n7;

    gln_arith #(
        .FRAC_BITS(FRAC_BITS)
    ) u_arith (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_res      = w_rsp.result;
    assign w_cos_sum  = gln_pkg::sat_add(r_sum, gln_pkg::sat_neg(w_res));
    assign w_omz      = gln_pkg::sat_sub(ONE, w_res);
    assign w_cv       = r_lower ? gln_pkg::sat_neg(r_z) : r_z;
    assign w_steps_nx = r_steps + 1'b1;
    assign w_n7       = {1'b0, i_node_index};
    assign w_lower    = ({i_node_index, 1'b1} < r_rule_order);

    // operand selection for the shared unit
    always_comb begin
        w_req.start = (r_state != S_IDLE) && (r_state != S_DONE) && !r_wait;
        w_req.op    = gln_pkg::AU_MUL;
        w_req.frac  = 1'b1;
        w_req.a     = '0;
        w_req.b     = '0;
        case (r_state)
            S_SEED_DIV: begin
                w_req.op = gln_pkg::AU_DIV;
                w_req.a  = 64'({r_i, 2'b11});
                w_req.b  = 64'({r_rule_order, 2'b10});
            end
            S_SEED_MUL: begin
                w_req.a = PI_FX;
                w_req.b = r_ta;
            end
            S_COS_T2: begin
                w_req.a = r_ta;
                w_req.b = r_ta;
            end
            S_COS_MUL: begin
                w_req.a = r_term;
                w_req.b = r_t2;
            end
            S_COS_DIV: begin
                w_req.op   = gln_pkg::AU_DIV;
                w_req.frac = 1'b0;
                w_req.a    = r_ta;
                w_req.b    = 64'(r_cdiv);
            end
            S_REC_M1: begin
                w_req.a = r_z;
                w_req.b = r_p1;
            end
            S_REC_M2: begin
                w_req.frac = 1'b0;
                w_req.a    = r_ta;
                w_req.b    = 64'({r_j, 1'b1});
            end
            S_REC_M3: begin
                w_req.frac = 1'b0;
                w_req.a    = r_p3;
                w_req.b    = 64'(r_j);
            end
            S_REC_DIV: begin
                w_req.op   = gln_pkg::AU_DIV;
                w_req.frac = 1'b0;
                w_req.a    = gln_pkg::sat_sub(r_ta, r_tb);
                w_req.b    = 64'(r_j) + 64'd1;
            end
            S_NT_D: begin
                w_req.a = r_z;
                w_req.b = r_p1;
            end
            S_NT_ZZ: begin
                w_req.a = r_z;
                w_req.b = r_z;
            end
            S_NT_NUM: begin
                w_req.a = r_p1;
                w_req.b = r_ta;
            end
            S_NT_DEN: begin
                w_req.frac = 1'b0;
                w_req.a    = r_d;
                w_req.b    = 64'(r_rule_order);
            end
            S_NT_DZ: begin
                w_req.op = gln_pkg::AU_DIV;
                w_req.a  = r_ta;
                w_req.b  = r_den;
            end
            S_W_ZZ: begin
                w_req.a = r_z1;
                w_req.b = r_z1;
            end
            S_W_DIV1, S_W_DIV2: begin
                w_req.op = gln_pkg::AU_DIV;
                w_req.a  = r_ta;
                w_req.b  = r_den;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_wait           <= 1'b0;
            r_rule_order     <= 7'd1;
            r_converge_limit <= 16'd4;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gln_pkg::REG_RULE_ORDER:     r_rule_order     <= i_cfg_data[6:0];
                    gln_pkg::REG_CONVERGE_LIMIT: r_converge_limit <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_coord     <= r_fc;
                r_weight    <= r_fw;
                r_status    <= r_fs;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_wait <= 1'b0;
                    if (w_in_acc) begin
                        if (r_rule_order == 7'd0 || int'(r_rule_order) > MAX_ORDER
                                || w_n7 >= r_rule_order) begin
                            r_fc    <= '0;
                            r_fw    <= '0;
                            r_fs    <= gln_pkg::ST_RANGE;
                            r_state <= S_DONE;
                        end else begin
                            r_lower <= w_lower;
                            r_i     <= w_lower ? w_n7 : r_rule_order - 7'd1 - w_n7;
                            r_steps <= '0;
                            r_state <= S_SEED_DIV;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    if (!r_wait) begin
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        case (r_state)
                            S_SEED_DIV: begin
                                r_ta    <= w_res;
                                r_state <= S_SEED_MUL;
                            end
                            S_SEED_MUL: begin
                                r_ta    <= w_res;
                                r_state <= S_COS_T2;
                            end
                            S_COS_T2: begin
                                r_t2    <= w_res;
                                r_term  <= ONE;
                                r_sum   <= ONE;
                                r_cn    <= 4'd1;
                                r_cdiv  <= 10'd2;
                                r_state <= S_COS_MUL;
                            end
                            S_COS_MUL: begin
                                r_ta    <= w_res;
                                r_state <= S_COS_DIV;
                            end
                            S_COS_DIV: begin
                                r_sum  <= w_cos_sum;
                                r_term <= gln_pkg::sat_neg(w_res);
                                if (int'(r_cn) == gln_pkg::COS_TERMS) begin
                                    r_z     <= w_cos_sum;
                                    r_p1    <= ONE;
                                    r_p2    <= '0;
                                    r_j     <= '0;
                                    r_state <= S_REC_M1;
                                end else begin
                                    // next divisor (2n+1)(2n+2) = (2n-1)2n + 8n + 2
                                    r_cdiv  <= r_cdiv + 10'({r_cn, 3'b010});
                                    r_cn    <= r_cn + 4'd1;
                                    r_state <= S_COS_MUL;
                                end
                            end
                            S_REC_M1: begin
                                r_p3    <= r_p2;
                                r_p2    <= r_p1;
                                r_ta    <= w_res;
                                r_state <= S_REC_M2;
                            end
                            S_REC_M2: begin
                                r_ta    <= w_res;
                                r_state <= S_REC_M3;
                            end
                            S_REC_M3: begin
                                r_tb    <= w_res;
                                r_state <= S_REC_DIV;
                            end
                            S_REC_DIV: begin
                                r_p1 <= w_res;
                                if (r_j + 7'd1 == r_rule_order) begin
                                    r_state <= S_NT_D;
                                end else begin
                                    r_j     <= r_j + 7'd1;
                                    r_state <= S_REC_M1;
                                end
                            end
                            S_NT_D: begin
                                r_d     <= gln_pkg::sat_sub(w_res, r_p2);
                                r_state <= S_NT_ZZ;
                            end
                            S_NT_ZZ: begin
                                r_ta    <= gln_pkg::sat_sub(w_res, ONE);
                                r_state <= S_NT_NUM;
                            end
                            S_NT_NUM: begin
                                r_ta    <= w_res;
                                r_state <= S_NT_DEN;
                            end
                            S_NT_DEN: begin
                                r_den   <= w_res;
                                r_state <= S_NT_DZ;
                            end
                            S_NT_DZ: begin
                                r_z1    <= r_z;
                                r_z     <= gln_pkg::sat_sub(r_z, w_res);
                                r_steps <= w_steps_nx;
                                if (gln_pkg::mag64(w_res) <= 64'(r_converge_limit)) begin
                                    r_fs    <= gln_pkg::ST_CONVERGED;
                                    r_state <= S_W_ZZ;
                                end else if (w_steps_nx >= STEP_W'(MAX_NEWTON_STEPS)) begin
                                    r_fs    <= gln_pkg::ST_LIMIT;
                                    r_state <= S_W_ZZ;
                                end else begin
                                    r_p1    <= ONE;
                                    r_p2    <= '0;
                                    r_j     <= '0;
                                    r_state <= S_REC_M1;
                                end
                            end
                            S_W_ZZ: begin
                                r_ta    <= gln_pkg::sat_add(w_omz, w_omz);
                                r_state <= S_W_DIV1;
                            end
                            S_W_DIV1: begin
                                r_ta    <= w_res;
                                r_state <= S_W_DIV2;
                            end
                            S_W_DIV2: begin
                                if (w_res < 0) begin
                                    r_fw <= '0;
                                end else if (w_res > C_MAX) begin
                                    r_fw <= '1;
                                end else begin
                                    r_fw <= w_res[46:0];
                                end
                                if (w_cv > C_MAX) begin
                                    r_fc <= C_MAX[47:0];
                                end else if (w_cv < C_MIN) begin
                                    r_fc <= C_MIN[47:0];
                                end else begin
                                    r_fc <= w_cv[47:0];
                                end
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_node_coord  = r_coord;
    assign o_node_weight = r_weight;
    assign o_status      = r_status;

endmodule
`default_nettype wire
